>>> hw/rtl/ssmr_pkg.sv
// package for the stack sum/max reducer
// holds widths, codes and the command/status types shared by controller and datapath
// no dependencies
package ssmr_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 32;
	localparam int DEPTH_W   = 7;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_SUM   = 2'd1,
		ACT_MAX   = 2'd2,
		ACT_DRAIN = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_COUNT = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// what the latched item needs
	typedef enum logic [2:0] {
		PLAN_FAIL,
		PLAN_PUSH,
		PLAN_KEEP,
		PLAN_LOOP,
		PLAN_MARK
	} plan_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_SINGLE,
		CMD_PUSH,
		CMD_MARK,
		CMD_LOOP_INIT,
		CMD_ISSUE,
		CMD_DRAIN_DONE,
		CMD_REDUCE_DONE
	} cmd_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_FLUSH,
		S_WRITE
	} ctrl_state_t;

	typedef struct packed {
		cmd_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		plan_t plan;
		logic  rd_last;
		logic  drain;
	} dp_stat_t;

endpackage

>>> hw/rtl/ssmr_ctrl.sv
// controller state machine for the stack sum/max reducer
// sequences the datapath through command codes; depends on ssmr_pkg
module ssmr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output ssmr_pkg::dp_cmd_t  cmd,
	input  ssmr_pkg::dp_stat_t stat
);
	import ssmr_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = CMD_NONE;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.op  = CMD_LATCH;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				case (stat.plan)
					PLAN_PUSH: cmd.op = CMD_PUSH;
					PLAN_MARK: cmd.op = CMD_MARK;
					PLAN_LOOP: begin
						cmd.op  = CMD_LOOP_INIT;
						state_d = S_READ;
					end
					default: cmd.op = CMD_SINGLE;
				endcase
			end
			S_READ: begin
				cmd.op = CMD_ISSUE;
				if (stat.rd_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				// last read word lands in this cycle
				if (stat.drain) begin
					cmd.op  = CMD_DRAIN_DONE;
					state_d = S_IDLE;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.op  = CMD_REDUCE_DONE;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/ssmr_datapath.sv
// datapath for the stack sum/max reducer: stack memory, depth, accumulator, result registers
// driven by ssmr_ctrl commands; depends on ssmr_pkg
module ssmr_datapath #(
	parameter int DEPTH = ssmr_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ssmr_pkg::dp_cmd_t                   cmd,
	output ssmr_pkg::dp_stat_t                  stat,
	input  logic [1:0]                          action,
	input  logic signed [ssmr_pkg::VAL_W-1:0]   operand,
	output logic                                strobe,
	output logic signed [ssmr_pkg::VAL_W-1:0]   value,
	output logic [ssmr_pkg::DEPTH_W-1:0]        depth,
	output logic [1:0]                          status,
	output logic                                is_entry,
	output logic                                last
);
	import ssmr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0]    FULL_DEPTH = CW'(DEPTH);
	localparam logic [VAL_W-1:0] VAL_MIN    = {1'b1, {(VAL_W-1){1'b0}}};

	logic [VAL_W-1:0] mem [DEPTH];

	act_t             act_q;
	logic [VAL_W-1:0] op_q;
	logic [CW-1:0]    depth_q;
	logic [VAL_W-1:0] top_q;
	logic [VAL_W-1:0] acc_q;
	logic [CW-1:0]    cnt_q;
	logic             rvalid_s1;
	logic             rlast_s1;
	logic [VAL_W-1:0] rd_data_s1;

	logic             strobe_q;
	logic [VAL_W-1:0] value_q;
	logic [CW-1:0]    depth_out_q;
	status_t          status_q;
	logic             is_entry_q;
	logic             last_q;

	logic             neg, big, full, empty;
	logic [CW-1:0]    kc, len, base_dn, new_base;
	plan_t            plan;
	status_t          code;
	logic [VAL_W-1:0] push_val, top_or_zero;
	logic             we;
	logic [AW-1:0]    waddr, raddr;
	logic [VAL_W-1:0] wdata;
	logic             rd_last;

	assign neg         = op_q[VAL_W-1];
	assign big         = op_q[VAL_W-2:0] > (VAL_W-1)'(depth_q);
	assign kc          = op_q[CW-1:0];
	assign full        = depth_q == FULL_DEPTH;
	assign empty       = depth_q == '0;
	assign top_or_zero = empty ? '0 : top_q;

	always_comb begin
		plan     = PLAN_FAIL;
		code     = ST_OK;
		len      = kc;
		push_val = op_q;
		case (act_q)
			ACT_PUSH: begin
				if (full) code = ST_FULL;
				else plan = PLAN_PUSH;
			end
			ACT_DRAIN: begin
				len  = depth_q;
				plan = empty ? PLAN_MARK : PLAN_LOOP;
			end
			ACT_SUM: begin
				if (neg || big) begin
					code = ST_BAD_COUNT;
				end else if (kc == '0) begin
					// sum of nothing pushes zero
					push_val = '0;
					if (full) code = ST_FULL;
					else plan = PLAN_PUSH;
				end else begin
					plan = PLAN_LOOP;
				end
			end
			ACT_MAX: begin
				if (neg || big || empty) code = ST_BAD_COUNT;
				else if (kc <= CW'(1)) plan = PLAN_KEEP;
				else plan = PLAN_LOOP;
			end
			default: ;
		endcase
	end

	assign rd_last  = cnt_q == (len - CW'(1));
	assign base_dn  = depth_q - CW'(1) - cnt_q;
	assign new_base = depth_q - len;
	assign raddr    = (act_q == ACT_DRAIN) ? cnt_q[AW-1:0] : base_dn[AW-1:0];

	assign stat.plan    = plan;
	assign stat.rd_last = rd_last;
	assign stat.drain   = act_q == ACT_DRAIN;

	always_comb begin
		we    = 1'b0;
		waddr = depth_q[AW-1:0];
		wdata = push_val;
		case (cmd.op)
			CMD_PUSH: we = 1'b1;
			CMD_REDUCE_DONE: begin
				we    = 1'b1;
				waddr = new_base[AW-1:0];
				wdata = acc_q;
			end
			default: ;
		endcase
	end

	// stack memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			rvalid_s1 <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.op == CMD_ISSUE;
			strobe_q  <= 1'b0;
			case (cmd.op)
				CMD_SINGLE, CMD_PUSH, CMD_MARK, CMD_REDUCE_DONE: strobe_q <= 1'b1;
				default: ;
			endcase
			if (rvalid_s1 && act_q == ACT_DRAIN) begin
				strobe_q <= 1'b1;
			end
			case (cmd.op)
				CMD_PUSH:        depth_q <= depth_q + CW'(1);
				CMD_DRAIN_DONE:  depth_q <= '0;
				CMD_REDUCE_DONE: depth_q <= new_base + CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rlast_s1 <= rd_last;
		case (cmd.op)
			CMD_LATCH: begin
				act_q <= act_t'(action);
				op_q  <= operand;
			end
			CMD_PUSH:        top_q <= push_val;
			CMD_REDUCE_DONE: top_q <= acc_q;
			CMD_LOOP_INIT: begin
				cnt_q <= '0;
				acc_q <= (act_q == ACT_MAX) ? VAL_MIN : '0;
			end
			CMD_ISSUE: cnt_q <= cnt_q + CW'(1);
			default: ;
		endcase

		if (rvalid_s1 && act_q != ACT_DRAIN) begin
			if (act_q == ACT_SUM) begin
				acc_q <= acc_q + rd_data_s1;
			end else if ($signed(rd_data_s1) > $signed(acc_q)) begin
				acc_q <= rd_data_s1;
			end
		end

		value_q     <= top_or_zero;
		depth_out_q <= depth_q;
		status_q    <= code;
		is_entry_q  <= 1'b0;
		last_q      <= 1'b1;
		case (cmd.op)
			CMD_PUSH: begin
				value_q     <= push_val;
				depth_out_q <= depth_q + CW'(1);
			end
			CMD_MARK: begin
				value_q     <= '0;
				depth_out_q <= '0;
				status_q    <= ST_OK;
			end
			CMD_REDUCE_DONE: begin
				value_q     <= acc_q;
				depth_out_q <= new_base + CW'(1);
				status_q    <= ST_OK;
			end
			default: ;
		endcase
		if (rvalid_s1 && act_q == ACT_DRAIN) begin
			value_q     <= rd_data_s1;
			depth_out_q <= '0;
			status_q    <= ST_OK;
			is_entry_q  <= 1'b1;
			last_q      <= rlast_s1;
		end
	end

	assign strobe   = strobe_q;
	assign value    = value_q;
	assign depth    = DEPTH_W'(depth_out_q);
	assign status   = status_q;
	assign is_entry = is_entry_q;
	assign last     = last_q;

endmodule

>>> hw/rtl/stack_sum_max_reducer_unit.sv
// stack sum/max reducer, top level: push, sum-reduce, max-reduce and drain on a bounded stack
// push, failed or trivial steps: the result is registered after the EXEC state and shows as the unit goes free
// reduce of k entries: EXEC, READ (one read per entry), FLUSH and WRITE; the result shows as the unit goes free
// drain of n entries: one result a cycle, one per entry, the last one as the unit goes free
// arst_n clears depth and control; stack contents are not cleared; results cannot be stalled
// depends on ssmr_pkg, ssmr_ctrl and ssmr_datapath
module stack_sum_max_reducer_unit #(
	parameter int DEPTH = ssmr_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        action,
	input  logic signed [ssmr_pkg::VAL_W-1:0] operand,
	output logic                              strobe,
	output logic signed [ssmr_pkg::VAL_W-1:0] value,
	output logic [ssmr_pkg::DEPTH_W-1:0]      depth,
	output logic [1:0]                        status,
	output logic                              is_entry,
	output logic                              last
);
	import ssmr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ssmr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	ssmr_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.action   (action),
		.operand  (operand),
		.strobe   (strobe),
		.value    (value),
		.depth    (depth),
		.status   (status),
		.is_entry (is_entry),
		.last     (last)
	);

	// an accepted transfer always leaves the unit busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("unit not busy after transfer");

	// the final result of an item coincides with the unit being free again
	a_last_free: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("final result while still busy");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final result after item finished");

	// drained entries report an empty stack and ok status
	a_entry_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && is_entry) |-> (depth == '0 && status == ST_OK))
		else $error("drained entry with bad depth or status");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (depth <= DEPTH_W'(DEPTH)))
		else $error("reported depth beyond capacity");

endmodule
